// ----- rtl/pps_pkg.sv -----
// Shared constants, types and control structs of the priority scheduler.
package pps_pkg;

	localparam int NUM_SLOTS_DEF = 16;

	localparam int SLOT_IN_W = 4;
	localparam int FIELD_W   = 16;
	localparam int TIME_W    = 32;

	// One table row: arrival, burst, remaining, priority from the lowest bit up
	localparam int ROW_W     = 4 * FIELD_W;
	localparam int ARR_LSB   = 0;
	localparam int BURST_LSB = FIELD_W;
	localparam int REM_LSB   = 2 * FIELD_W;
	localparam int PRIO_LSB  = 3 * FIELD_W;

	localparam int S_TDATA_W = 56;
	localparam int M_TDATA_W = 104;
	localparam int M_TUSER_W = 2;

	typedef enum logic {
		OP_LOAD = 1'b0,
		OP_TICK = 1'b1
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic load;    // write one slot from the input request
		logic clear;   // start of a tick: drop best candidate, rewind scan
		logic rd;      // issue one table read at the scan address
		logic finish;  // run the chosen slot, step time, load result
	} cmd_t;

	typedef struct packed {
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/pps_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module pps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pps_ctrl.sv -----
// Sequencer of the scheduler: load of each load request; scan, drain and finish of each tick.
module pps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_op,
	input  pps_pkg::status_t  stat,
	output logic              s_tready,
	output pps_pkg::cmd_t     cmd
);

	pps_pkg::state_t state_q, state_nx;
	logic            accept;

	assign accept = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= pps_pkg::ST_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				if (accept && s_op == pps_pkg::OP_TICK) begin
					state_nx = pps_pkg::ST_SCAN;
				end
			end
			pps_pkg::ST_SCAN: begin
				if (stat.scan_last) begin
					state_nx = pps_pkg::ST_DRAIN;
				end
			end
			pps_pkg::ST_DRAIN: begin
				state_nx = pps_pkg::ST_FINISH;
			end
			pps_pkg::ST_FINISH: begin
				if (stat.out_free) begin
					state_nx = pps_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nx = pps_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		s_tready   = 1'b0;
		cmd        = '0;
		case (state_q)
			pps_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.load  = accept && s_op == pps_pkg::OP_LOAD;
				cmd.clear = accept && s_op == pps_pkg::OP_TICK;
			end
			pps_pkg::ST_SCAN: begin
				cmd.rd = 1'b1;
			end
			pps_pkg::ST_DRAIN: begin
			end
			pps_pkg::ST_FINISH: begin
				cmd.finish = stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/pps_dp.sv -----
// Datapath: slot table, scan compare, time counter and result register.
module pps_dp #(
	parameter int NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  pps_pkg::cmd_t                   cmd,
	input  logic [pps_pkg::S_TDATA_W-1:0]   s_tdata,
	output pps_pkg::status_t                stat,
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [pps_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [pps_pkg::M_TUSER_W-1:0]   m_tuser
);

	localparam int SLOT_W = $clog2(NUM_SLOTS);
	localparam int FW     = pps_pkg::FIELD_W;
	localparam int TW     = pps_pkg::TIME_W;

	// request fields
	logic [pps_pkg::SLOT_IN_W-1:0] in_slot;
	logic [FW-1:0]                 in_arr, in_burst, in_prio;
	logic                          load_ok;
	logic [SLOT_W-1:0]             load_idx;

	assign in_slot  = s_tdata[3:0];
	assign in_arr   = s_tdata[19:4];
	assign in_burst = s_tdata[35:20];
	assign in_prio  = s_tdata[51:36];
	assign load_ok  = 32'(in_slot) < NUM_SLOTS;
	assign load_idx = SLOT_W'(in_slot);

	// table
	logic [NUM_SLOTS-1:0]       valid_q;
	logic                       ram_we;
	logic [SLOT_W-1:0]          ram_waddr;
	logic [pps_pkg::ROW_W-1:0]  ram_wdata, ram_rdata;

	// scan
	logic [SLOT_W-1:0] cnt_q;
	logic              rd_s1, vld_s1;
	logic [SLOT_W-1:0] addr_s1;

	// best candidate
	logic              have_q;
	logic [SLOT_W-1:0] best_slot_q;
	logic [FW-1:0]     best_arr_q, best_burst_q, best_rem_q, best_prio_q;

	logic [TW-1:0]     time_q;

	logic [FW-1:0]     r_arr, r_burst, r_rem, r_prio;
	logic              ready_slot, take;

	logic [TW-1:0]     time_nx, tat, wt;
	logic [FW-1:0]     rem_dec;
	logic              fin;

	// result register
	logic                          out_vld_q;
	logic [pps_pkg::SLOT_IN_W-1:0] out_slot_q;
	logic                          out_idle_q, out_fin_q;
	logic [TW-1:0]                 out_wt_q, out_tat_q, out_now_q;

	pps_ram #(
		.WIDTH (pps_pkg::ROW_W),
		.DEPTH (NUM_SLOTS)
	) u_table (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.rd),
		.raddr (cnt_q),
		.rdata (ram_rdata)
	);

	always_comb begin
		ram_we    = (cmd.load && load_ok) || (cmd.finish && have_q);
		ram_waddr = best_slot_q;
		ram_wdata = {best_prio_q, rem_dec, best_burst_q, best_arr_q};
		if (cmd.load) begin
			ram_waddr = load_idx;
			ram_wdata = {in_prio, in_burst, in_burst, in_arr};
		end
	end

	assign r_arr   = ram_rdata[pps_pkg::ARR_LSB   +: FW];
	assign r_burst = ram_rdata[pps_pkg::BURST_LSB +: FW];
	assign r_rem   = ram_rdata[pps_pkg::REM_LSB   +: FW];
	assign r_prio  = ram_rdata[pps_pkg::PRIO_LSB  +: FW];

	// unwritten slots read as empty through the valid bit
	assign ready_slot = rd_s1 && vld_s1 && r_rem != '0 && TW'(r_arr) <= time_q;
	// strict compare keeps the lowest slot on a tie
	assign take       = ready_slot && (!have_q || r_prio < best_prio_q);

	assign time_nx = time_q + TW'(1);
	assign rem_dec = best_rem_q - FW'(1);
	assign fin     = have_q && rem_dec == '0;
	assign tat     = time_nx - TW'(best_arr_q);
	assign wt      = tat - TW'(best_burst_q);

	assign stat.scan_last = cnt_q == SLOT_W'(NUM_SLOTS - 1);
	assign stat.out_free  = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= '0;
			cnt_q     <= '0;
			rd_s1     <= 1'b0;
			have_q    <= 1'b0;
			time_q    <= '0;
			out_vld_q <= 1'b0;
		end else begin
			rd_s1 <= cmd.rd;
			if (cmd.load && load_ok) begin
				valid_q[load_idx] <= 1'b1;
				time_q            <= '0;
			end
			if (cmd.clear) begin
				cnt_q  <= '0;
				have_q <= 1'b0;
			end else begin
				if (cmd.rd) begin
					cnt_q <= cnt_q + SLOT_W'(1);
				end
				if (take) begin
					have_q <= 1'b1;
				end
			end
			if (cmd.finish) begin
				time_q    <= time_nx;
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.rd) begin
			addr_s1 <= cnt_q;
			vld_s1  <= valid_q[cnt_q];
		end
		if (take) begin
			best_slot_q  <= addr_s1;
			best_arr_q   <= r_arr;
			best_burst_q <= r_burst;
			best_rem_q   <= r_rem;
			best_prio_q  <= r_prio;
		end
		if (cmd.finish) begin
			out_slot_q <= have_q ? pps_pkg::SLOT_IN_W'(best_slot_q) : '0;
			out_idle_q <= !have_q;
			out_fin_q  <= fin;
			out_wt_q   <= fin ? wt : '0;
			out_tat_q  <= fin ? tat : '0;
			out_now_q  <= time_nx;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0, out_now_q, out_tat_q, out_wt_q, out_slot_q};
	assign m_tuser  = {out_fin_q, out_idle_q};

`ifndef SYNTHESIS
	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_vld_q || m_tready))
		else $error("result overwritten before it was taken");

	a_finish_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_vld_q)
		else $error("finished tick gave no result");

	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && out_idle_q) |-> (!out_fin_q && out_wt_q == '0 && out_tat_q == '0))
		else $error("idle tick reports a completion");

	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear || cmd.load) |-> !(cmd.rd || cmd.finish))
		else $error("table write overlaps a scan");
`endif

endmodule

// ----- rtl/preemptive_priority_scheduler_top.sv -----
// Top level of the tick-driven preemptive priority scheduler.
//
//  channel   dir  handshake            payload
//  s_*       in   s_tvalid/s_tready    tuser: operation; tdata: slot, arrival, burst, priority
//  m_*       out  m_tvalid/m_tready    tuser: idle, finished; tdata: slot, wait, turnaround, now
//
// A load request gives no result.
// A tick request makes one table read per slot through the
// single read port of the slot RAM, drains the last read, then finishes.
// arst_n clears the valid bits, time counter and all handshake state; no clearing pass.
// A held result stalls the finish of the next tick; no request is taken while that finish waits.
module preemptive_priority_scheduler_top #(
	parameter int NUM_SLOTS = pps_pkg::NUM_SLOTS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          s_tvalid,
	output logic                          s_tready,
	// [3:0] slot, [19:4] arrival_time, [35:20] burst_length, [51:36] priority_req
	input  logic [pps_pkg::S_TDATA_W-1:0] s_tdata,
	// [0] operation
	input  logic                          s_tuser,
	output logic                          m_tvalid,
	input  logic                          m_tready,
	// [3:0] chosen_slot, [35:4] wait_time, [67:36] turnaround_time, [99:68] now
	output logic [pps_pkg::M_TDATA_W-1:0] m_tdata,
	// [0] idle, [1] finished
	output logic [pps_pkg::M_TUSER_W-1:0] m_tuser
);

	pps_pkg::cmd_t    cmd;
	pps_pkg::status_t stat;

	pps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_op     (s_tuser),
		.stat     (stat),
		.s_tready (s_tready),
		.cmd      (cmd)
	);

	pps_dp #(
		.NUM_SLOTS (NUM_SLOTS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.s_tdata  (s_tdata),
		.stat     (stat),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule
